[rtl/pin_claim_table_unit_assert.svh]
// assertion macros for the pin claim table unit
// no dependencies; included by the top level
`ifndef PIN_CLAIM_TABLE_UNIT_ASSERT_SVH
`define PIN_CLAIM_TABLE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pct_pkg.sv]
// shared types and codes of the pin claim table unit
// no dependencies
package pct_pkg;

  localparam int PIN_BITS        = 7;
  localparam int TPIN_BITS       = 6;
  localparam int OWNER_PORT_BITS = 8;
  localparam int VERDICT_BITS    = 2;
  localparam int STATUS_BITS     = 2;

  localparam logic [VERDICT_BITS-1:0] V_NEW     = 2'd0;
  localparam logic [VERDICT_BITS-1:0] V_SAME    = 2'd1;
  localparam logic [VERDICT_BITS-1:0] V_TAKEN   = 2'd2;
  localparam logic [VERDICT_BITS-1:0] V_INVALID = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_REFUSED  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_OVERSIZE = 2'd3;

  typedef struct packed {
    logic signed [PIN_BITS-1:0] pin_echo;
    logic [VERDICT_BITS-1:0]    verdict;
    logic [OWNER_PORT_BITS-1:0] blocking_owner;
    logic [STATUS_BITS-1:0]     batch_status;
    logic                       final_result;
  } result_t;

endpackage

[rtl/pin_claim_table_unit.sv]
// top level of the pin claim table unit: sequencer plus table and batch memories
// depends on pct_pkg, pct_ram, pct_ctrl and pin_claim_table_unit_assert.svh
//
//   channel   handshake              beat
//   claim in  start && !busy         pin_number, owner_id, last_in_batch
//   result    done (one cycle)       pin_echo, verdict, blocking_owner,
//                                    batch_status, final_result
//
// a claim holds busy while table and batch entries are scanned and while it is stored,
// since each memory's single read port checks one entry a cycle; an invalid pin skips
// the scans and goes straight to the store step
// the closing claim adds a status step and then the emission of the results
// rst is synchronous and empties table and batch; memories are not cleared
// results cannot be stalled and leave one a cycle; the last one of a batch
// shows in the same cycle that busy falls, an oversize report with busy low
`include "pin_claim_table_unit_assert.svh"

module pin_claim_table_unit #(
  parameter int TABLE_DEPTH = 32,
  parameter int BATCH_DEPTH = 16,
  parameter int HIGHEST_PIN = 48,
  parameter int OWNER_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pct_pkg::PIN_BITS-1:0] pin_number,
  input  logic [pct_pkg::OWNER_PORT_BITS-1:0] owner_id,
  input  logic                                last_in_batch,
  output logic                                done,
  output logic signed [pct_pkg::PIN_BITS-1:0] pin_echo,
  output logic [pct_pkg::VERDICT_BITS-1:0]    verdict,
  output logic [pct_pkg::OWNER_PORT_BITS-1:0] blocking_owner,
  output logic [pct_pkg::STATUS_BITS-1:0]     batch_status,
  output logic                                final_result
);
  import pct_pkg::*;

  localparam int OW  = (OWNER_BITS < OWNER_PORT_BITS) ? OWNER_BITS : OWNER_PORT_BITS;
  localparam int TIW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BIW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int TFW = $clog2(TABLE_DEPTH + 1);
  localparam int BFW = $clog2(BATCH_DEPTH + 1);
  localparam int TW  = TPIN_BITS + OW;
  localparam int BW  = PIN_BITS + OW + VERDICT_BITS + OW;

  result_t        res;
  logic           t_we;
  logic [TIW-1:0] t_waddr;
  logic [TW-1:0]  t_wdata;
  logic [TIW-1:0] t_raddr;
  logic [TW-1:0]  t_rdata;
  logic           b_we;
  logic [BIW-1:0] b_waddr;
  logic [BW-1:0]  b_wdata;
  logic [BIW-1:0] b_raddr;
  logic [BW-1:0]  b_rdata;

  pct_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .BATCH_DEPTH (BATCH_DEPTH),
    .HIGHEST_PIN (HIGHEST_PIN),
    .OW          (OW),
    .TIW         (TIW),
    .BIW         (BIW),
    .TFW         (TFW),
    .BFW         (BFW),
    .TW          (TW),
    .BW          (BW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .pin_number    (pin_number),
    .owner_id      (owner_id),
    .last_in_batch (last_in_batch),
    .busy          (busy),
    .done          (done),
    .res           (res),
    .t_we          (t_we),
    .t_waddr       (t_waddr),
    .t_wdata       (t_wdata),
    .t_raddr       (t_raddr),
    .t_rdata       (t_rdata),
    .b_we          (b_we),
    .b_waddr       (b_waddr),
    .b_wdata       (b_wdata),
    .b_raddr       (b_raddr),
    .b_rdata       (b_rdata)
  );

  // stored claims: pin and owner
  pct_ram #(
    .WIDTH (TW),
    .DEPTH (TABLE_DEPTH),
    .AW    (TIW)
  ) u_table_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // open batch: pin, owner, verdict, blocker
  pct_ram #(
    .WIDTH (BW),
    .DEPTH (BATCH_DEPTH),
    .AW    (BIW)
  ) u_batch_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign pin_echo       = res.pin_echo;
  assign verdict        = res.verdict;
  assign blocking_owner = res.blocking_owner;
  assign batch_status   = res.batch_status;
  assign final_result   = res.final_result;

  `PCT_ASSERT_NOW(a_mid_batch_busy, clk, rst, done && !final_result, busy,
    "non-final result seen while idle")
  `PCT_ASSERT_NEXT(a_open_claim_silent, clk, rst, start && !busy && !last_in_batch,
    !done, "result after a claim that does not close its batch")
  `PCT_ASSERT_NOW(a_accept_clean, clk, rst, done && batch_status == ST_ACCEPTED,
    verdict != V_TAKEN && verdict != V_INVALID, "accepted batch holds a blocking verdict")
  `PCT_ASSERT_NOW(a_busy_from_start, clk, rst, $rose(busy), $past(start),
    "busy raised without a start beat")

endmodule

[rtl/pct_ram.sv]
// simple dual port memory, one write and one registered read per cycle
// no dependencies
module pct_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pct_ctrl.sv]
// sequencer: judges each claim by scanning table and batch memories,
// then reports the batch and, if accepted, appends its new pins. depends on pct_pkg
module pct_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int BATCH_DEPTH = 16,
  parameter int HIGHEST_PIN = 48,
  parameter int OW          = 8,
  parameter int TIW         = 5,
  parameter int BIW         = 4,
  parameter int TFW         = 6,
  parameter int BFW         = 5,
  parameter int TW          = 14,
  parameter int BW          = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pct_pkg::PIN_BITS-1:0] pin_number,
  input  logic [pct_pkg::OWNER_PORT_BITS-1:0] owner_id,
  input  logic                                last_in_batch,
  output logic                                busy,
  output logic                                done,
  output pct_pkg::result_t                    res,
  output logic                                t_we,
  output logic [TIW-1:0]                      t_waddr,
  output logic [TW-1:0]                       t_wdata,
  output logic [TIW-1:0]                      t_raddr,
  input  logic [TW-1:0]                       t_rdata,
  output logic                                b_we,
  output logic [BIW-1:0]                      b_waddr,
  output logic [BW-1:0]                       b_wdata,
  output logic [BIW-1:0]                      b_raddr,
  input  logic [BW-1:0]                       b_rdata
);
  import pct_pkg::*;

  localparam int CW = (TIW > BIW) ? TIW : BIW;
  localparam int SW0 = (TFW > BFW) ? TFW : BFW;
  localparam int SW = ((SW0 > CW + 1) ? SW0 : CW + 1) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TSCAN  = 3'd1;
  localparam logic [2:0] S_BSCAN  = 3'd2;
  localparam logic [2:0] S_STORE  = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]                 state;
  logic [TFW-1:0]             table_fill;
  logic [BFW-1:0]             batch_fill;
  logic [BFW-1:0]             new_cnt;
  logic                       refused;
  logic [CW-1:0]              cnt;
  logic signed [PIN_BITS-1:0] pin_q;
  logic [OW-1:0]              owner_q;
  logic                       last_q;
  logic [VERDICT_BITS-1:0]    verdict_q;
  logic [OW-1:0]              blocker_q;
  logic [STATUS_BITS-1:0]     status_q;

  logic                       accept;
  logic                       pin_ok;
  logic [CW:0]                cnt_inc;
  logic                       t_end;
  logic                       b_end;
  logic [TPIN_BITS-1:0]       t_pin;
  logic [OW-1:0]              t_own;
  logic signed [PIN_BITS-1:0] b_pin;
  logic [OW-1:0]              b_own;
  logic [VERDICT_BITS-1:0]    b_ver;
  logic [OW-1:0]              b_blk;
  logic                       full;
  logic                       blocking;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pin_ok  = !pin_number[PIN_BITS-1] &&
                   (pin_number[TPIN_BITS-1:0] <= TPIN_BITS'(HIGHEST_PIN));
  assign cnt_inc = {1'b0, cnt} + 1'b1;
  assign t_end   = (SW'(cnt_inc) == SW'(table_fill));
  assign b_end   = (SW'(cnt_inc) == SW'(batch_fill));

  assign t_pin = t_rdata[TW-1 -: TPIN_BITS];
  assign t_own = t_rdata[OW-1:0];
  assign b_pin = b_rdata[BW-1 -: PIN_BITS];
  assign b_own = b_rdata[2*OW+VERDICT_BITS-1 -: OW];
  assign b_ver = b_rdata[OW+VERDICT_BITS-1 -: VERDICT_BITS];
  assign b_blk = b_rdata[OW-1:0];

  assign full     = (SW'(table_fill) + SW'(new_cnt)) > SW'(TABLE_DEPTH);
  assign blocking = verdict_q inside {V_TAKEN, V_INVALID};

  // read addresses run one entry ahead of the compare; park on entry 0
  assign t_raddr = (state == S_TSCAN) ? cnt_inc[TIW-1:0] : '0;
  assign b_raddr = (state == S_BSCAN || state == S_EMIT) ? cnt_inc[BIW-1:0] : '0;

  assign b_we    = (state == S_STORE);
  assign b_waddr = batch_fill[BIW-1:0];
  assign b_wdata = {pin_q, owner_q, verdict_q, blocker_q};

  // accepted batch appends its new pins while being reported
  assign t_we    = (state == S_EMIT) && (status_q == ST_ACCEPTED) && (b_ver == V_NEW);
  assign t_waddr = table_fill[TIW-1:0];
  assign t_wdata = {b_pin[TPIN_BITS-1:0], b_own};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_fill <= '0;
      batch_fill <= '0;
      new_cnt    <= '0;
      refused    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pin_q     <= pin_number;
            owner_q   <= owner_id[OW-1:0];
            last_q    <= last_in_batch;
            blocker_q <= '0;
            cnt       <= '0;
            // a full batch buffer drops the claim; the closing one reports oversize
            if (SW'(batch_fill) >= SW'(BATCH_DEPTH)) begin
              if (last_in_batch) begin
                done               <= 1'b1;
                res.pin_echo       <= pin_number;
                res.verdict        <= V_NEW;
                res.blocking_owner <= '0;
                res.batch_status   <= ST_OVERSIZE;
                res.final_result   <= 1'b1;
                batch_fill         <= '0;
                new_cnt            <= '0;
                refused            <= 1'b0;
              end
            end else if (!pin_ok) begin
              verdict_q <= V_INVALID;
              state     <= S_STORE;
            end else if (table_fill != '0) begin
              state <= S_TSCAN;
            end else if (batch_fill != '0) begin
              state <= S_BSCAN;
            end else begin
              verdict_q <= V_NEW;
              state     <= S_STORE;
            end
          end
        end
        S_TSCAN: begin
          if (t_pin == pin_q[TPIN_BITS-1:0]) begin
            verdict_q <= (t_own == owner_q) ? V_SAME : V_TAKEN;
            blocker_q <= t_own;
            state     <= S_STORE;
          end else if (t_end) begin
            cnt <= '0;
            if (batch_fill != '0) begin
              state <= S_BSCAN;
            end else begin
              verdict_q <= V_NEW;
              state     <= S_STORE;
            end
          end else begin
            cnt <= cnt_inc[CW-1:0];
          end
        end
        S_BSCAN: begin
          if (b_pin == pin_q) begin
            verdict_q <= (b_own == owner_q) ? V_SAME : V_TAKEN;
            blocker_q <= b_own;
            state     <= S_STORE;
          end else if (b_end) begin
            verdict_q <= V_NEW;
            state     <= S_STORE;
          end else begin
            cnt <= cnt_inc[CW-1:0];
          end
        end
        S_STORE: begin
          batch_fill <= batch_fill + 1'b1;
          if (blocking) begin
            refused <= 1'b1;
          end
          if (verdict_q == V_NEW) begin
            new_cnt <= new_cnt + 1'b1;
          end
          state <= last_q ? S_STATUS : S_IDLE;
        end
        S_STATUS: begin
          cnt <= '0;
          if (refused) begin
            status_q <= ST_REFUSED;
          end else if (full) begin
            status_q <= ST_FULL;
          end else begin
            status_q <= ST_ACCEPTED;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          done               <= 1'b1;
          res.pin_echo       <= b_pin;
          res.verdict        <= b_ver;
          res.blocking_owner <= OWNER_PORT_BITS'(b_blk);
          res.batch_status   <= status_q;
          res.final_result   <= b_end;
          if (t_we) begin
            table_fill <= table_fill + 1'b1;
          end
          if (b_end) begin
            batch_fill <= '0;
            new_cnt    <= '0;
            refused    <= 1'b0;
            state      <= S_IDLE;
          end else begin
            cnt <= cnt_inc[CW-1:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
